/* design/assert_macros.svh */
// Assertion helpers included by the blit engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* design/mfbe_pkg.sv */
`timescale 1ns / 1ps

package mfbe_pkg;

  localparam int SCREEN_W_DEF  = 400;
  localparam int SCREEN_H_DEF  = 240;
  localparam int BLIT_BITS_DEF = 24;
  localparam int WORD_BITS     = 64;

  localparam logic [2:0] OP_BLIT       = 3'd0;
  localparam logic [2:0] OP_FILL       = 3'd1;
  localparam logic [2:0] OP_CLEAR_ALL  = 3'd2;
  localparam logic [2:0] OP_TAKE_DIRTY = 3'd3;
  localparam logic [2:0] OP_READ_WORD  = 3'd4;

  localparam logic [1:0] MODE_OR     = 2'd0;
  localparam logic [1:0] MODE_XOR    = 2'd1;
  localparam logic [1:0] MODE_ANDNOT = 2'd2;
  localparam logic [1:0] MODE_BAD    = 2'd3;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_REJECT   = 2'd1;
  localparam logic [1:0] STAT_NO_DIRTY = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SWEEP,
    ST_SCAN,
    ST_READ_RD,
    ST_READ_WT,
    ST_RESP
  } state_e;

endpackage

/* design/mfbe_if.sv */
`timescale 1ns / 1ps

interface mfbe_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [8:0]  x_pos;
  logic [8:0]  span_width;
  logic [7:0]  y_pos;
  logic [7:0]  span_height;
  logic [23:0] pixel_value;
  logic [1:0]  blit_mode;
  logic        fill_set;
  logic [2:0]  word_index;

  modport source (output valid, opcode, x_pos, span_width, y_pos, span_height,
                  pixel_value, blit_mode, fill_set, word_index, input ready);
  modport sink (input valid, opcode, x_pos, span_width, y_pos, span_height,
                pixel_value, blit_mode, fill_set, word_index, output ready);
endinterface

interface mfbe_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  row_index;
  logic [63:0] row_word;

  modport source (output valid, status, row_index, row_word, input ready);
  modport sink (input valid, status, row_index, row_word, output ready);
endinterface

/* design/mfbe_store.sv */
`timescale 1ns / 1ps

module mfbe_store #(
  parameter int DEPTH = 1680,
  parameter int AW    = 11,
  parameter int DW    = mfbe_pkg::WORD_BITS
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

/* design/mono_framebuffer_blit_engine_unit.sv */
`timescale 1ns / 1ps
// A blit reads each touched 64-bit word and writes it back, a read fetches one word,
// a rectangle fill rewrites every touched word of each row, clear-all sets every word
// and dirty flag, and a dirty scan walks the rows up to the first set flag. One item is
// in work at a time; the single-port frame memory and its read-modify-write loop set the
// rate. After reset a clearing pass over all SCREEN_H*ceil(SCREEN_W/64) words (1680 at the
// defaults) zeroes the frame memory and the dirty flags; no item is accepted until it ends.

`include "assert_macros.svh"

module mono_framebuffer_blit_engine_unit #(
  parameter int SCREEN_W  = mfbe_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H  = mfbe_pkg::SCREEN_H_DEF,
  parameter int BLIT_BITS = mfbe_pkg::BLIT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfbe_req_if.sink  req_i,
  mfbe_rsp_if.source rsp_o
);

  localparam int WB        = mfbe_pkg::WORD_BITS;
  localparam int WPR       = (SCREEN_W + WB - 1) / WB;
  localparam int DEPTH     = SCREEN_H * WPR;
  localparam int AW        = $clog2(DEPTH);
  localparam int WW        = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int RW        = $clog2(SCREEN_H);
  localparam int CW        = $clog2(SCREEN_W);
  localparam int LAST_BITS = SCREEN_W - WB * (WPR - 1);
  localparam logic [WB-1:0] LAST_MASK = {WB{1'b1}} >> (WB - LAST_BITS);

  mfbe_pkg::state_e state_q, state_d;

  logic [AW-1:0]        rowbase_q, rowbase_d;
  logic [AW-1:0]        sweep_q, sweep_d;
  logic                 sweep_val_q, sweep_val_d;
  logic [WW-1:0]        wrd_q, wrd_d, wlo_q, wlo_d, whi_q, whi_d;
  logic [RW-1:0]        row_q, row_d, row_end_q, row_end_d;
  logic [CW-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [1:0]           mode_q, mode_d;
  logic                 is_fill_q, is_fill_d;
  logic [BLIT_BITS-1:0] src_q, src_d;
  logic [1:0]           res_status_q, res_status_d;
  logic [7:0]           res_row_q, res_row_d;
  logic [WB-1:0]        res_word_q, res_word_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [7:0]           out_row_q, out_row_d;
  logic [WB-1:0]        out_word_q, out_word_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [WB-1:0]        mem_wdata, mem_rdata;

  logic                 dirty_we, dirty_wdata, dirty_rdata;
  logic [RW-1:0]        dirty_addr;

  logic [10:0]          sum_x, lo_w, hi_w;
  logic [8:0]           sum_y;
  logic [BLIT_BITS-1:0] dmask, src_eff;
  logic                 blit_bad, fill_bad, read_bad;
  logic [5:0]           lo_rel, hi_rel;
  logic [WB-1:0]        wmask, wsrc;
  logic [2*WB-1:0]      src_wide;

  mfbe_store #(.DEPTH(DEPTH), .AW(AW), .DW(WB)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  mfbe_store #(.DEPTH(SCREEN_H), .AW(RW), .DW(1)) u_dirty (
    .clk_i   (clk_i),
    .we_i    (dirty_we),
    .addr_i  (dirty_addr),
    .wdata_i (dirty_wdata),
    .rdata_o (dirty_rdata)
  );

  assign req_i.ready     = (state_q == mfbe_pkg::ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.row_index = out_row_q;
  assign rsp_o.row_word  = out_word_q;

  always_comb begin
    sum_x    = 11'(req_i.x_pos) + 11'(req_i.span_width);
    lo_w     = 11'(SCREEN_W) - sum_x;
    hi_w     = 11'(SCREEN_W) - 11'(req_i.x_pos) - 11'd1;
    sum_y    = 9'(req_i.y_pos) + 9'(req_i.span_height);
    dmask    = ~({BLIT_BITS{1'b1}} << req_i.span_width);
    if (req_i.fill_set && req_i.blit_mode != mfbe_pkg::MODE_XOR) begin
      src_eff = (req_i.blit_mode == mfbe_pkg::MODE_ANDNOT) ? dmask : '0;
    end else begin
      src_eff = BLIT_BITS'(req_i.pixel_value) & dmask;
    end
    blit_bad = (req_i.span_width == 9'd0) || (int'(req_i.span_width) > BLIT_BITS) ||
               (int'(sum_x) > SCREEN_W) || (int'(req_i.y_pos) >= SCREEN_H) ||
               (req_i.blit_mode == mfbe_pkg::MODE_BAD);
    fill_bad = (int'(sum_x) > SCREEN_W) || (int'(sum_y) > SCREEN_H);
    read_bad = (int'(req_i.y_pos) >= SCREEN_H) || (int'(req_i.word_index) >= WPR);

    lo_rel   = (wrd_q == wlo_q) ? lo_q[5:0] : 6'd0;
    hi_rel   = (wrd_q == whi_q) ? hi_q[5:0] : 6'd63;
    wmask    = ({WB{1'b1}} << lo_rel) & ({WB{1'b1}} >> (6'd63 - hi_rel));
    src_wide = (2*WB)'(src_q) << lo_q[5:0];
    if (is_fill_q) begin
      wsrc = wmask;
    end else begin
      wsrc = (wrd_q == wlo_q) ? src_wide[WB-1:0] : src_wide[2*WB-1:WB];
    end
  end

  always_comb begin
    state_d      = state_q;
    rowbase_d    = rowbase_q;
    sweep_d      = sweep_q;
    sweep_val_d  = sweep_val_q;
    wrd_d        = wrd_q;
    wlo_d        = wlo_q;
    whi_d        = whi_q;
    row_d        = row_q;
    row_end_d    = row_end_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mode_d       = mode_q;
    is_fill_d    = is_fill_q;
    src_d        = src_q;
    res_status_d = res_status_q;
    res_row_d    = res_row_q;
    res_word_d   = res_word_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_row_d    = out_row_q;
    out_word_d   = out_word_q;
    mem_we       = 1'b0;
    mem_addr     = rowbase_q + AW'(wrd_q);
    mem_wdata    = '0;
    dirty_we     = 1'b0;
    dirty_wdata  = 1'b0;
    dirty_addr   = row_q;

    case (state_q)
      mfbe_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = '0;
        if (int'(sweep_q) < SCREEN_H) begin
          dirty_we   = 1'b1;
          dirty_addr = RW'(sweep_q);
        end
        sweep_d   = sweep_q + AW'(1);
        if (sweep_q == AW'(DEPTH - 1)) begin
          state_d = mfbe_pkg::ST_IDLE;
        end
      end
      mfbe_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          res_status_d = mfbe_pkg::STAT_DONE;
          res_row_d    = '0;
          res_word_d   = '0;
          lo_d         = CW'(lo_w);
          hi_d         = CW'(hi_w);
          wlo_d        = WW'(lo_w >> 6);
          whi_d        = WW'(hi_w >> 6);
          wrd_d        = WW'(lo_w >> 6);
          row_d        = RW'(req_i.y_pos);
          rowbase_d    = AW'(int'(req_i.y_pos) * WPR);
          case (req_i.opcode)
            mfbe_pkg::OP_BLIT: begin
              if (blit_bad) begin
                res_status_d = mfbe_pkg::STAT_REJECT;
                state_d      = mfbe_pkg::ST_RESP;
              end else begin
                row_end_d = RW'(req_i.y_pos);
                mode_d    = req_i.blit_mode;
                is_fill_d = 1'b0;
                src_d     = src_eff;
                state_d   = mfbe_pkg::ST_RMW_RD;
              end
            end
            mfbe_pkg::OP_FILL: begin
              if (fill_bad) begin
                res_status_d = mfbe_pkg::STAT_REJECT;
                state_d      = mfbe_pkg::ST_RESP;
              end else if (req_i.span_width == 9'd0 || req_i.span_height == 8'd0) begin
                state_d = mfbe_pkg::ST_RESP;
              end else begin
                row_end_d = RW'(sum_y - 9'd1);
                mode_d    = (req_i.pixel_value != 24'd0) ? mfbe_pkg::MODE_OR
                                                         : mfbe_pkg::MODE_ANDNOT;
                is_fill_d = 1'b1;
                state_d   = mfbe_pkg::ST_RMW_RD;
              end
            end
            mfbe_pkg::OP_CLEAR_ALL: begin
              sweep_d     = '0;
              sweep_val_d = 1'b1;
              state_d     = mfbe_pkg::ST_SWEEP;
            end
            mfbe_pkg::OP_TAKE_DIRTY: begin
              row_d   = '0;
              state_d = mfbe_pkg::ST_SCAN;
            end
            mfbe_pkg::OP_READ_WORD: begin
              if (read_bad) begin
                res_status_d = mfbe_pkg::STAT_REJECT;
                state_d      = mfbe_pkg::ST_RESP;
              end else begin
                wrd_d   = WW'(req_i.word_index);
                state_d = mfbe_pkg::ST_READ_RD;
              end
            end
            default: begin
              res_status_d = mfbe_pkg::STAT_REJECT;
              state_d      = mfbe_pkg::ST_RESP;
            end
          endcase
        end
      end
      mfbe_pkg::ST_RMW_RD: begin
        state_d = mfbe_pkg::ST_RMW_WR;
      end
      mfbe_pkg::ST_RMW_WR: begin
        mem_we = 1'b1;
        case (mode_q)
          mfbe_pkg::MODE_OR:  mem_wdata = mem_rdata | wsrc;
          mfbe_pkg::MODE_XOR: mem_wdata = mem_rdata ^ wsrc;
          default:            mem_wdata = mem_rdata & ~wsrc;
        endcase
        dirty_we    = 1'b1;
        dirty_wdata = 1'b1;
        state_d     = mfbe_pkg::ST_RMW_RD;
        if (wrd_q == whi_q) begin
          if (row_q == row_end_q) begin
            state_d = mfbe_pkg::ST_RESP;
          end else begin
            row_d     = row_q + RW'(1);
            rowbase_d = rowbase_q + AW'(WPR);
            wrd_d     = wlo_q;
          end
        end else begin
          wrd_d = wrd_q + WW'(1);
        end
      end
      mfbe_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = {WB{sweep_val_q}};
        if (int'(sweep_q) < SCREEN_H) begin
          dirty_we    = 1'b1;
          dirty_wdata = sweep_val_q;
          dirty_addr  = RW'(sweep_q);
        end
        sweep_d   = sweep_q + AW'(1);
        if (sweep_q == AW'(DEPTH - 1)) begin
          state_d = mfbe_pkg::ST_RESP;
        end
      end
      mfbe_pkg::ST_SCAN: begin
        if (dirty_rdata) begin
          dirty_we    = 1'b1;
          dirty_wdata = 1'b0;
          res_row_d   = 8'(row_q);
          state_d     = mfbe_pkg::ST_RESP;
        end else if (row_q == RW'(SCREEN_H - 1)) begin
          res_status_d = mfbe_pkg::STAT_NO_DIRTY;
          state_d      = mfbe_pkg::ST_RESP;
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      mfbe_pkg::ST_READ_RD: begin
        state_d = mfbe_pkg::ST_READ_WT;
      end
      mfbe_pkg::ST_READ_WT: begin
        res_word_d = mem_rdata & ((wrd_q == WW'(WPR - 1)) ? LAST_MASK : {WB{1'b1}});
        res_row_d  = 8'(row_q);
        state_d    = mfbe_pkg::ST_RESP;
      end
      mfbe_pkg::ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_row_d    = res_row_q;
          out_word_d   = res_word_q;
          state_d      = mfbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mfbe_pkg::ST_IDLE;
      end
    endcase

    // The flag memory looks one row ahead, so its output matches row_q in the next cycle.
    if (!dirty_we) begin
      dirty_addr = row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfbe_pkg::ST_INIT;
      sweep_q     <= '0;
      sweep_val_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      sweep_val_q <= sweep_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rowbase_q    <= rowbase_d;
    wrd_q        <= wrd_d;
    wlo_q        <= wlo_d;
    whi_q        <= whi_d;
    row_q        <= row_d;
    row_end_q    <= row_end_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mode_q       <= mode_d;
    is_fill_q    <= is_fill_d;
    src_q        <= src_d;
    res_status_q <= res_status_d;
    res_row_q    <= res_row_d;
    res_word_q   <= res_word_d;
    out_status_q <= out_status_d;
    out_row_q    <= out_row_d;
    out_word_q   <= out_word_d;
  end

  `ASSERT_AT(a_accept_drops_ready, clk_i, rst_ni, req_i.valid && req_i.ready |=> !req_i.ready, "ready stayed high after an accepted item")
  `ASSERT_AT(a_no_dirty_zero, clk_i, rst_ni, rsp_o.valid && rsp_o.status == mfbe_pkg::STAT_NO_DIRTY |-> rsp_o.row_index == 8'd0 && rsp_o.row_word == '0, "no-dirty result carries data")
  `ASSERT_AT(a_write_states, clk_i, rst_ni, mem_we |-> state_q == mfbe_pkg::ST_RMW_WR || state_q == mfbe_pkg::ST_SWEEP || state_q == mfbe_pkg::ST_INIT, "frame memory written outside a write state")
  `ASSERT_AT(a_scan_clears, clk_i, rst_ni, state_q == mfbe_pkg::ST_SCAN && dirty_rdata |-> dirty_we && !dirty_wdata && dirty_addr == row_q, "taken dirty row was not cleared")
  `ASSERT_NEVER(a_status_code, clk_i, rst_ni, rsp_o.valid && rsp_o.status != mfbe_pkg::STAT_DONE && rsp_o.status != mfbe_pkg::STAT_REJECT && rsp_o.status != mfbe_pkg::STAT_NO_DIRTY, "unknown status code")

endmodule
